// ===== hw/rtl/mhc_pkg.sv =====
package mhc_pkg;

    localparam int TABLE_BITS = 12;
    localparam int EPOCH_BITS = 32;
    localparam int WORD_W     = 64;
    localparam int HALF_W     = WORD_W / 2;
    localparam int SHIFT_W    = 6;
    localparam int SLOT_W     = 12;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int S_DATA_W   = 2 * WORD_W;
    localparam int M_DATA_W   = ((STATUS_W + SLOT_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_DATA_W - STATUS_W - SLOT_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = CFG_IDX_W'(1);

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(52);

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STAT_OK     = 2'd0;
    localparam status_t STAT_REJECT = 2'd1;
    localparam status_t STAT_PASS   = 2'd2;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic slot;
        logic read;
        logic commit;
        logic clr_step;
    } mhc_cmd_t;

    typedef struct packed {
        logic wrap;
        logic clr_done;
    } mhc_sts_t;

endpackage

// ===== hw/rtl/magic_hash_collision_check.sv =====
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: occupancy, attack_set; tuser: first_of_trial;
//                                   tlast: last_of_trial
// m_*       out  m_tvalid/m_tready  tdata: status, slot_index
// cfg_*     in   cfg_we             cfg_addr: 0 magic, 1 shift; cfg_wdata
//
// States MUL, SUM, SLOT, READ and LOOK run the split 64-bit multiply, the product sum,
// the shift, the tag/attack memory read and the read-modify-write decision in turn, and
// the next item is accepted only after that. A first item whose epoch advance wraps adds
// a sweep of all 4096 tags. After reset the tags are swept to zero with s_tready low.
// One result waits in the output register; a stalled m_tready holds the next item in lookup.
module magic_hash_collision_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mhc_pkg::S_DATA_W-1:0]        s_tdata,   // occupancy, attack_set
    input  logic                                s_tuser,   // first_of_trial
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mhc_pkg::M_DATA_W-1:0]        m_tdata,   // status, slot_index, zero pad
    input  logic                                cfg_we,
    input  logic [mhc_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [mhc_pkg::WORD_W-1:0]          cfg_wdata
);
    import mhc_pkg::*;

    mhc_cmd_t cmd;
    mhc_sts_t sts;

    mhc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    mhc_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .in_first  (s_tuser),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (m_tdata)
    );

endmodule

// ===== hw/rtl/mhc_dpath.sv =====
module mhc_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mhc_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [mhc_pkg::WORD_W-1:0]          cfg_wdata,
    input  logic [mhc_pkg::S_DATA_W-1:0]        in_data,
    input  logic                                in_first,
    input  logic                                in_last,
    input  mhc_pkg::mhc_cmd_t                   cmd,
    output mhc_pkg::mhc_sts_t                   sts,
    output logic [mhc_pkg::M_DATA_W-1:0]        out_data
);
    import mhc_pkg::*;

    localparam int DEPTH = 1 << TABLE_BITS;

    logic [WORD_W-1:0]     magic_reg;
    logic [SHIFT_W-1:0]    shift_reg;
    logic [EPOCH_BITS-1:0] epoch_reg;
    logic                  failed_reg;
    logic [TABLE_BITS-1:0] cnt_reg;

    logic [WORD_W-1:0]     occ_reg;
    logic [WORD_W-1:0]     atk_reg;
    logic                  last_reg;

    logic [WORD_W-1:0]     pp_ll_reg;
    logic [HALF_W-1:0]     pp_lh_reg;
    logic [HALF_W-1:0]     pp_hl_reg;
    logic [WORD_W-1:0]     prod_reg;
    logic [TABLE_BITS-1:0] addr_reg;

    logic [EPOCH_BITS-1:0] tag_mem [DEPTH];
    logic [WORD_W-1:0]     atk_mem [DEPTH];
    logic [EPOCH_BITS-1:0] tag_rd_reg;
    logic [WORD_W-1:0]     atk_rd_reg;

    status_t               status_reg;
    logic [SLOT_W-1:0]     slot_out_reg;

    logic [WORD_W-1:0]     pp_ll_next;
    logic [HALF_W-1:0]     pp_lh_next;
    logic [HALF_W-1:0]     pp_hl_next;
    logic [WORD_W-1:0]     prod_next;
    logic [TABLE_BITS-1:0] addr_next;
    logic [EPOCH_BITS-1:0] epoch_next;
    logic                  claim;
    logic                  conflict;
    logic                  failed_next;
    status_t               status_next;
    logic                  tag_we;
    logic [TABLE_BITS-1:0] tag_waddr;
    logic [EPOCH_BITS-1:0] tag_wdata;

    assign sts.wrap     = in_first & (&epoch_reg);
    assign sts.clr_done = &cnt_reg;

    // low 64 bits of the product from three 32x32 partial products
    always_comb
    begin
        pp_ll_next = WORD_W'(magic_reg[HALF_W-1:0]) * WORD_W'(occ_reg[HALF_W-1:0]);
        pp_lh_next = magic_reg[HALF_W-1:0] * occ_reg[WORD_W-1:HALF_W];
        pp_hl_next = magic_reg[WORD_W-1:HALF_W] * occ_reg[HALF_W-1:0];
        prod_next  = pp_ll_reg + {pp_lh_reg + pp_hl_reg, {HALF_W{1'b0}}};
        addr_next  = TABLE_BITS'(prod_reg >> shift_reg);
    end

    always_comb
    begin
        epoch_next = epoch_reg + EPOCH_BITS'(1);
        if (sts.wrap)
        begin
            epoch_next = EPOCH_BITS'(1);
        end
    end

    always_comb
    begin
        claim       = !failed_reg && (tag_rd_reg != epoch_reg);
        conflict    = !failed_reg && (tag_rd_reg == epoch_reg) && (atk_rd_reg != atk_reg);
        failed_next = failed_reg | conflict;
        if (failed_next)
        begin
            status_next = STAT_REJECT;
        end
        else if (last_reg)
        begin
            status_next = STAT_PASS;
        end
        else
        begin
            status_next = STAT_OK;
        end
    end

    // tag write port shared by the clearing sweep and slot claims
    always_comb
    begin
        tag_we    = cmd.clr_step | (cmd.commit & claim);
        tag_waddr = cmd.clr_step ? cnt_reg : addr_reg;
        tag_wdata = cmd.clr_step ? '0 : epoch_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg  <= '0;
            shift_reg  <= SHIFT_RESET;
            epoch_reg  <= '0;
            failed_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_MAGIC: magic_reg <= cfg_wdata;
                    CFG_SHIFT: shift_reg <= cfg_wdata[SHIFT_W-1:0];
                    default:   magic_reg <= magic_reg;
                endcase
            end
            if (cmd.load && in_first)
            begin
                epoch_reg  <= epoch_next;
                failed_reg <= 1'b0;
            end
            else if (cmd.commit)
            begin
                failed_reg <= failed_next;
            end
            if (cmd.clr_step)
            begin
                cnt_reg <= cnt_reg + TABLE_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            occ_reg  <= in_data[WORD_W-1:0];
            atk_reg  <= in_data[S_DATA_W-1:WORD_W];
            last_reg <= in_last;
        end
        if (cmd.mul)
        begin
            pp_ll_reg <= pp_ll_next;
            pp_lh_reg <= pp_lh_next;
            pp_hl_reg <= pp_hl_next;
        end
        if (cmd.sum)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.slot)
        begin
            addr_reg <= addr_next;
        end
        if (cmd.commit)
        begin
            status_reg   <= status_next;
            slot_out_reg <= SLOT_W'(addr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        if (cmd.read)
        begin
            tag_rd_reg <= tag_mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && claim)
        begin
            atk_mem[addr_reg] <= atk_reg;
        end
        if (cmd.read)
        begin
            atk_rd_reg <= atk_mem[addr_reg];
        end
    end

    assign out_data = {{M_PAD_W{1'b0}}, slot_out_reg, status_reg};

endmodule

// ===== hw/rtl/mhc_ctrl.sv =====
module mhc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output mhc_pkg::mhc_cmd_t  cmd,
    input  mhc_pkg::mhc_sts_t  sts
);
    import mhc_pkg::*;

    typedef enum logic [7:0] {
        ST_INIT = 8'b0000_0001,
        ST_IDLE = 8'b0000_0010,
        ST_WIPE = 8'b0000_0100,
        ST_MUL  = 8'b0000_1000,
        ST_SUM  = 8'b0001_0000,
        ST_SLOT = 8'b0010_0000,
        ST_READ = 8'b0100_0000,
        ST_LOOK = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.wrap ? ST_WIPE : ST_MUL;
                end
            end
            ST_WIPE:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_SLOT;
            end
            ST_SLOT:
            begin
                cmd.slot   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    a_wrap_wipes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && sts.wrap |=> state_reg == ST_WIPE)
        else $error("epoch wrap did not start a tag sweep");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while an item is in flight");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid)
        else $error("committed result not presented");

    a_rise_from_look: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_LOOK))
        else $error("result appeared outside lookup");

    a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INIT |-> !m_tvalid && !s_tready)
        else $error("traffic during tag sweep after reset");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    import mhc_pkg::*;

    localparam int          IDLE_LIMIT  = 20000;
    localparam int          LONG_HOLD   = 300;
    localparam int          PRINT_LIMIT = 100;
    localparam logic [63:0] ODD_MIX     = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot;
    } hash_result_t;

    typedef struct packed {
        logic [63:0]  occ;
        logic [63:0]  atk;
        logic         first;
        logic         last;
        logic         typed;
        hash_result_t want;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;   // occupancy, attack_set
    logic                   s_tuser;   // first_of_trial
    logic                   s_tlast;   // last_of_trial
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;   // status, slot_index, zero pad
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_addr;
    logic [WORD_W-1:0]      cfg_wdata;

    // predictor copy of the block state
    logic [EPOCH_BITS-1:0]  tag_mem    [1 << TABLE_BITS];
    logic [63:0]            attack_mem [1 << TABLE_BITS];
    logic [EPOCH_BITS-1:0]  trial_epoch;
    logic                   trial_rejected;
    logic [63:0]            cur_magic;
    logic [SHIFT_W-1:0]     cur_shift;

    hash_result_t           pending_results [$];
    int unsigned            mismatch_count;
    int unsigned            idle_cycles = 0;
    bit                     tx_quiet;
    bit                     rx_quiet;
    bit                     long_hold_req;

    // magic 1, shift 52: the slot is simply occupancy[63:52]
    directed_row_t directed_rows [0:19] = '{
        '{64'h0, 64'h0, 1'b1, 1'b0, 1'b1, '{STAT_OK, 12'h000}},
        '{64'h0010_0000_0000_0000, ALL_ONES, 1'b0, 1'b0, 1'b1, '{STAT_OK, 12'h001}},
        '{64'h1, 64'h0, 1'b0, 1'b0, 1'b1, '{STAT_OK, 12'h000}},
        '{ALL_ONES, ALL_ONES, 1'b0, 1'b0, 1'b1, '{STAT_OK, 12'hFFF}},
        '{64'h0010_0000_0000_0000, ALL_ONES, 1'b0, 1'b0, 1'b1, '{STAT_OK, 12'h001}},
        '{64'h001F_FFFF_FFFF_FFFF, 64'h5, 1'b0, 1'b0, 1'b1, '{STAT_REJECT, 12'h001}},
        '{ALL_ONES, 64'h7B, 1'b0, 1'b0, 1'b1, '{STAT_REJECT, 12'hFFF}},
        '{64'h0, 64'h0, 1'b0, 1'b1, 1'b1, '{STAT_REJECT, 12'h000}},
        '{64'h8000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1, 1'b1,
          '{STAT_PASS, 12'h800}},
        '{64'h0010_0000_0000_0000, 64'h7, 1'b1, 1'b0, 1'b1, '{STAT_OK, 12'h001}},
        '{64'h0020_0000_0000_0000, 64'h7, 1'b0, 1'b1, 1'b1, '{STAT_PASS, 12'h002}},
        '{64'h0, 64'h5555_5555_5555_5555, 1'b1, 1'b0, 1'b1, '{STAT_OK, 12'h000}},
        '{64'h1, 64'h5555_5555_5555_5555, 1'b0, 1'b1, 1'b1, '{STAT_PASS, 12'h000}},
        '{64'h0030_0000_0000_0000, 64'h1, 1'b1, 1'b0, 1'b1, '{STAT_OK, 12'h003}},
        '{64'h003F_0000_0000_0000, 64'h2, 1'b0, 1'b1, 1'b1, '{STAT_REJECT, 12'h003}},
        '{64'h0040_0000_0000_0000, 64'h9, 1'b1, 1'b0, 1'b1, '{STAT_OK, 12'h004}},
        '{64'h0040_0000_0000_0001, 64'hA, 1'b0, 1'b0, 1'b1, '{STAT_REJECT, 12'h004}},
        '{64'h0040_0000_0000_0000, 64'hA, 1'b1, 1'b1, 1'b1, '{STAT_PASS, 12'h004}},
        '{64'h1234_5678_9ABC_DEF0, 64'hDEAD_BEEF_0BAD_F00D, 1'b1, 1'b0, 1'b0,
          '{STAT_OK, 12'h000}},
        '{64'h1234_5678_9ABC_DEF0, 64'hDEAD_BEEF_0BAD_F00D, 1'b0, 1'b1, 1'b0,
          '{STAT_OK, 12'h000}}
    };

    magic_hash_collision_check u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic hash_result_t hash_and_claim(input logic [63:0] occ,
                                                    input logic [63:0] atk,
                                                    input logic first,
                                                    input logic last);
        logic [63:0]            product;
        logic [TABLE_BITS-1:0]  addr;
        logic [EPOCH_BITS-1:0]  next_epoch;
        hash_result_t           res;
        if (first)
        begin
            next_epoch = trial_epoch + EPOCH_BITS'(1);
            // wrap: clear all tags, restart at 1
            if (next_epoch == '0)
            begin
                foreach (tag_mem[i])
                    tag_mem[i] = '0;
                next_epoch = EPOCH_BITS'(1);
            end
            trial_epoch    = next_epoch;
            trial_rejected = 1'b0;
        end
        product = cur_magic * occ;
        addr    = TABLE_BITS'(product >> cur_shift);
        if (!trial_rejected)
        begin
            if (tag_mem[addr] != trial_epoch)
            begin
                tag_mem[addr]    = trial_epoch;
                attack_mem[addr] = atk;
            end
            else if (attack_mem[addr] != atk)
                trial_rejected = 1'b1;
        end
        res.status = trial_rejected ? STAT_REJECT : (last ? STAT_PASS : STAT_OK);
        res.slot   = SLOT_W'(addr);
        return res;
    endfunction

    // append one expected result at the tail of the pending list
    function automatic void enqueue_result(input hash_result_t res);
        pending_results = {pending_results, res};
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // both registers back to back, write enable held across the pair
    task automatic load_config(input logic [63:0] magic_val, input logic [SHIFT_W-1:0] shift_val);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_MAGIC;
        cfg_wdata <= magic_val;
        @(posedge clk);
        cfg_addr  <= CFG_SHIFT;
        cfg_wdata <= WORD_W'(shift_val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_magic  = magic_val;
        cur_shift  = shift_val;
    endtask

    task automatic offer_pair(input logic [63:0] occ, input logic [63:0] atk,
                              input logic first, input logic last,
                              input logic typed, input hash_result_t typed_res);
        int unsigned  gap;
        hash_result_t res;
        gap = tx_quiet ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {atk, occ};
        s_tuser  <= first;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        res = hash_and_claim(occ, atk, first, last);
        enqueue_result(typed ? typed_res : res);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_trials(input int unsigned budget);
        int unsigned  sent;
        int unsigned  kind;
        int unsigned  len;
        logic [63:0]  mask;
        logic [63:0]  salt;
        logic [63:0]  occ;
        logic [63:0]  atk;
        logic         first;
        logic         last;
        sent = 0;
        occ  = '0;
        while (sent < budget)
        begin
            tx_quiet = ($urandom_range(0, 4) == 0);
            kind     = $urandom_range(0, 9);
            len      = $urandom_range(1, 12);
            mask     = rand64() & rand64();
            salt     = rand64();
            for (int i = 0; i < len; i++)
            begin
                if (kind == 9)
                begin
                    // noise: everything random
                    occ   = rand64();
                    atk   = rand64();
                    first = 1'($urandom_range(0, 1));
                    last  = 1'($urandom_range(0, 1));
                end
                else
                begin
                    // repeat an occupancy now and then to hit a constructive collision
                    if (i == 0 || $urandom_range(0, 7) != 0)
                        occ = mask & rand64();
                    atk   = (occ * ODD_MIX) ^ salt;
                    if ($urandom_range(0, 15) == 0)
                        atk = rand64();
                    first = (i == 0) && (kind != 8);
                    last  = (i == len - 1) && (kind != 7);
                end
                offer_pair(occ, atk, first, last, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // receiver: random stalls, quiet stretches, one long hold on request
    initial
    begin
        int unsigned  stall;
        int unsigned  served;
        hash_result_t got;
        hash_result_t want;
        served   = 0;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (served % 32 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            stall = rx_quiet ? 0 : $urandom_range(0, 6);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall         = LONG_HOLD;
            end
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            served++;
            got.status = m_tdata[STATUS_W-1:0];
            got.slot   = m_tdata[STATUS_W +: SLOT_W];
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", 64'(got), 64'h0);
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.slot !== want.slot)
                    report_mismatch("slot_index", 64'(got.slot), 64'(want.slot));
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n          <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= 1'b0;
        s_tlast        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_addr       <= CFG_MAGIC;
        cfg_wdata      <= '0;
        mismatch_count  = 0;
        tx_quiet        = 1'b0;
        rx_quiet        = 1'b0;
        long_hold_req   = 1'b0;
        foreach (tag_mem[i])
        begin
            tag_mem[i]    = '0;
            attack_mem[i] = '0;
        end
        trial_epoch    = '0;
        trial_rejected = 1'b0;
        cur_magic      = '0;
        cur_shift      = SHIFT_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_config(64'h1, SHIFT_RESET);
        foreach (directed_rows[r])
            offer_pair(directed_rows[r].occ, directed_rows[r].atk, directed_rows[r].first,
                       directed_rows[r].last, directed_rows[r].typed, directed_rows[r].want);
        drain_results();

        // zero multiplier: every pair lands in slot 0
        load_config(64'h0, SHIFT_RESET);
        run_trials(300);
        drain_results();

        // widest shift, all-ones multiplier; back up the output meanwhile
        load_config(ALL_ONES, 6'd63);
        long_hold_req = 1'b1;
        run_trials(300);
        drain_results();

        load_config(rand64() | 64'h1, 6'd58);
        run_trials(400);
        drain_results();

        // shift below 64 - TABLE_BITS: the address keeps only the low product bits
        load_config(rand64(), 6'd20);
        run_trials(300);
        drain_results();

        load_config(rand64(), SHIFT_RESET);
        run_trials(450);
        drain_results();

        repeat (12) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
